// ----- sv/acm_pkg.sv -----
// ----------------------------------------------------------------------------
// acm_pkg: shared types and constants of the converter channel monitor
// Filter and check constants, register indexes, config and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package acm_pkg;

  localparam int FILTER_SHIFT  = 2;
  localparam int ADC_MAX       = 4095;
  localparam int MIN_SENSORS   = 2;
  localparam int NUM_CHANNELS  = 8;

  localparam int CH_W          = 3;
  localparam int SAMPLE_W      = 12;
  localparam int VALUE_W       = 13;
  localparam int FREG_W        = 16;
  localparam int NUM_THERM     = 6;
  localparam int NUM_CHAMBER   = 4;
  localparam int CHAMBER_BASE  = 2;
  localparam int CH_MOIST      = 6;
  localparam int CH_SUPPLY     = 7;
  localparam int LEAK_DEBOUNCE = 7;
  localparam int LEAK_CNT_W    = 8;
  localparam int DELAY_W       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 13;
  localparam int LIMIT_W       = 12;
  localparam int CNT_FOUND_W   = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_OPEN_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_HIGH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_DELAY   = 3'd7;

  // reset values
  localparam logic [VALUE_W-1:0] RST_OPEN_LIMIT     = 13'd100;
  localparam logic [VALUE_W-1:0] RST_PIN_OPEN_LIMIT = 13'd7800;
  localparam logic [VALUE_W-1:0] RST_SHORT_LIMIT    = 13'd7900;
  localparam logic [LIMIT_W-1:0] RST_LEAK_LOW       = 12'd1000;
  localparam logic [LIMIT_W-1:0] RST_LEAK_HIGH      = 12'd4000;
  localparam logic [LIMIT_W-1:0] RST_SUPPLY_LOW     = 12'd1800;
  localparam logic [LIMIT_W-1:0] RST_SUPPLY_HIGH    = 12'd2300;
  localparam logic [DELAY_W-1:0] RST_DETECT_DELAY   = 8'd4;

  typedef struct packed {
    logic [VALUE_W-1:0] open_limit;
    logic [VALUE_W-1:0] pin_open_limit;
    logic [VALUE_W-1:0] short_limit;
    logic [LIMIT_W-1:0] leak_low;
    logic [LIMIT_W-1:0] leak_high;
    logic [LIMIT_W-1:0] supply_low;
    logic [LIMIT_W-1:0] supply_high;
    logic [DELAY_W-1:0] detect_delay_scans;
  } cfg_t;

  typedef struct packed {
    logic [NUM_THERM-1:0]   open_faults;
    logic [NUM_THERM-1:0]   short_faults;
    logic                   supply_fault;
    logic                   leak_fault;
    logic [NUM_CHAMBER-1:0] detected_mask;
    logic                   sensors_valid;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/acm_filter.sv -----
// ----------------------------------------------------------------------------
// acm_filter: per-channel first-order low-pass filter
// Holds one filter register per channel and forms the reported value.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_filter
  import acm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                upd,
  input  wire logic [CH_W-1:0]     ch,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic      [VALUE_W-1:0]  value
);

  logic [FREG_W-1:0] freg_r [NUM_CHANNELS];
  logic [FREG_W-1:0] freg_nxt;
  logic [FREG_W-1:0] cur;
  logic [FREG_W:0]   sum;
  logic [FREG_W-1:0] filt;
  logic [FREG_W-1:0] diff;

  always_comb begin
    cur  = freg_r[ch];
    sum  = {1'b0, cur} - {1'b0, (cur >> FILTER_SHIFT)} + (FREG_W+1)'(sample);
    if (cur != '0) begin
      freg_nxt = sum[FREG_W-1:0];
    end else begin
      freg_nxt = FREG_W'(sample) << FILTER_SHIFT;
    end
    filt = freg_nxt >> FILTER_SHIFT;
    diff = FREG_W'(ADC_MAX) - filt;
    if (ch < CH_W'(NUM_THERM)) begin
      // thermistors read inverted and doubled, floor at zero
      if (filt > FREG_W'(ADC_MAX)) begin
        value = '0;
      end else begin
        value = {diff[VALUE_W-2:0], 1'b0};
      end
    end else begin
      value = filt[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        freg_r[i] <= '0;
      end
    end else if (upd) begin
      freg_r[ch] <= freg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/acm_check.sv -----
// ----------------------------------------------------------------------------
// acm_check: fault checks, leak debounce and chamber sensor detection
// Keeps the fault flags, the power-on scan delay and the last values.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_check
  import acm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 upd,
  input  wire logic [CH_W-1:0]      ch,
  input  wire logic [VALUE_W-1:0]   value,
  input  wire logic [NUM_THERM-1:0] pins,
  input  wire logic                 tick,
  input  wire cfg_t                 cfg,
  input  wire logic                 delay_wr,
  input  wire logic [DELAY_W-1:0]   delay_wr_val,
  output status_t                   status
);

  logic [VALUE_W-1:0]     last_r [NUM_CHANNELS];
  logic [DELAY_W-1:0]     delay_left_r, delay_left_nxt;
  logic [NUM_THERM-1:0]   open_r, open_nxt;
  logic [NUM_THERM-1:0]   short_r, short_nxt;
  logic                   supply_r, supply_nxt;
  logic                   leak_seen_r, leak_seen_nxt;
  logic [LEAK_CNT_W-1:0]  leak_cnt_r, leak_cnt_nxt;
  logic                   leak_r, leak_nxt;
  logic [NUM_CHAMBER-1:0] det_r, det_nxt;
  logic                   valid_r, valid_nxt;

  logic                   chk;
  logic                   therm_en;
  logic [1:0]             cidx;
  logic                   io;
  logic                   ob;
  logic                   sb;
  logic                   bad;
  logic [NUM_CHAMBER-1:0] found;
  logic [CNT_FOUND_W-1:0] nfound;
  logic [VALUE_W-1:0]     lv;

  always_comb begin
    chk      = (delay_left_r == '0);
    cidx     = 2'(ch - CH_W'(CHAMBER_BASE));
    therm_en = (ch < CH_W'(NUM_THERM)) &&
               ((ch < CH_W'(CHAMBER_BASE)) || det_r[cidx]);

    // thermistor open and short, pin input only decides near the top
    io = 1'b0;
    if (value < cfg.open_limit) begin
      ob = 1'b1;
    end else if (value > cfg.pin_open_limit) begin
      io = (ch < CH_W'(NUM_THERM)) ? pins[ch] : 1'b0;
      ob = io;
    end else begin
      ob = 1'b0;
    end
    sb = (value > cfg.short_limit) && !io;

    open_nxt  = open_r;
    short_nxt = short_r;
    if (chk && therm_en) begin
      open_nxt[ch]  = ob;
      short_nxt[ch] = sb;
    end

    // leak debounce
    bad           = (value < VALUE_W'(cfg.leak_low)) || (value > VALUE_W'(cfg.leak_high));
    leak_seen_nxt = leak_seen_r;
    leak_cnt_nxt  = leak_cnt_r;
    leak_nxt      = leak_r;
    if (chk && ch == CH_W'(CH_MOIST)) begin
      leak_seen_nxt = leak_seen_r | bad;
      if (leak_seen_nxt && tick) begin
        if (bad) begin
          if (leak_cnt_r != '1) begin
            leak_cnt_nxt = leak_cnt_r + 1'b1;
          end
        end else begin
          leak_cnt_nxt = '0;
        end
      end
      if (leak_cnt_nxt > LEAK_CNT_W'(LEAK_DEBOUNCE)) begin
        leak_nxt = 1'b1;
      end
    end

    supply_nxt = supply_r;
    if (chk && ch == CH_W'(CH_SUPPLY)) begin
      supply_nxt = (value > VALUE_W'(cfg.supply_high)) ||
                   (value < VALUE_W'(cfg.supply_low));
    end

    // chamber presence from stored values
    nfound = '0;
    for (int k = 0; k < NUM_CHAMBER; k++) begin
      lv       = last_r[k + CHAMBER_BASE];
      found[k] = ((lv < cfg.short_limit) && (lv > cfg.open_limit)) ||
                 ((lv >= cfg.short_limit) && !pins[k + CHAMBER_BASE]);
      nfound   = nfound + CNT_FOUND_W'(found[k]);
    end

    delay_left_nxt = delay_left_r;
    det_nxt        = det_r;
    valid_nxt      = valid_r;
    if (ch == CH_W'(CH_SUPPLY) && !chk) begin
      delay_left_nxt = delay_left_r - 1'b1;
      if (delay_left_r == DELAY_W'(1)) begin
        det_nxt = det_r | found;
        if (det_nxt == '0) begin
          det_nxt = NUM_CHAMBER'(1);
        end
        valid_nxt = (nfound >= CNT_FOUND_W'(MIN_SENSORS));
      end
    end

    status.open_faults   = open_nxt;
    status.short_faults  = short_nxt;
    status.supply_fault  = supply_nxt;
    status.leak_fault    = leak_nxt;
    status.detected_mask = det_nxt;
    status.sensors_valid = valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_r[i] <= '0;
      end
      delay_left_r <= RST_DETECT_DELAY;
      open_r       <= '0;
      short_r      <= '0;
      supply_r     <= 1'b0;
      leak_seen_r  <= 1'b0;
      leak_cnt_r   <= '0;
      leak_r       <= 1'b0;
      det_r        <= '0;
      valid_r      <= 1'b0;
    end else if (delay_wr) begin
      delay_left_r <= delay_wr_val;
    end else if (upd) begin
      last_r[ch]   <= value;
      delay_left_r <= delay_left_nxt;
      open_r       <= open_nxt;
      short_r      <= short_nxt;
      supply_r     <= supply_nxt;
      leak_seen_r  <= leak_seen_nxt;
      leak_cnt_r   <= leak_cnt_nxt;
      leak_r       <= leak_nxt;
      det_r        <= det_nxt;
      valid_r      <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/adc_channel_monitor.sv -----
// ----------------------------------------------------------------------------
// adc_channel_monitor: eight-channel converter sample monitor
// Samples arrive in a fixed rotation: inlet, outlet, four chamber
// thermistors, moisture, supply. Each word on the in_ channel carries one
// sample with the pin-open bits and the leak debounce tick; each word on
// the out_ channel gives the channel, its filtered value and all fault and
// detection flags as they stand after that sample.
// A word is taken when valid is high and stall is low. An input register
// and a result register surround one pass of filter and check logic, so a
// word goes from the input register through that logic into the result
// register, and one word per cycle is sustained while out_ is not stalled.
// The channel filters and flags are read and written in that single pass,
// which allows that rate. When the receiver stalls, the result register
// holds and in_stall rises once the input register is also full; nothing
// is lost. Reset (rst_n low, synchronous) clears filters, flags and the
// rotation and loads the register defaults. The cfg_ port is always ready;
// the user must write it only while the block is idle, which the block does
// not enforce. Writing the delay register restarts the power-on scan delay.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_channel_monitor
  import acm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_W-1:0]    in_sample,
  input  wire logic [NUM_THERM-1:0]   in_pin_open_bits,
  input  wire logic                   in_debounce_tick,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [CH_W-1:0]        out_channel,
  output logic      [VALUE_W-1:0]     out_value,
  output logic      [NUM_THERM-1:0]   out_open_faults,
  output logic      [NUM_THERM-1:0]   out_short_faults,
  output logic                        out_supply_fault,
  output logic                        out_leak_fault,
  output logic      [NUM_CHAMBER-1:0] out_detected_mask,
  output logic                        out_sensors_valid,

  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                 in_vld_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [NUM_THERM-1:0] pins_r;
  logic                 tick_r;
  logic [CH_W-1:0]      ch_r;
  logic                 out_vld_r;
  logic [CH_W-1:0]      out_ch_r;
  logic [VALUE_W-1:0]   out_value_r;
  status_t              out_status_r;
  cfg_t                 cfg_r;

  logic                 adv;
  logic                 in_acc;
  logic                 cfg_wr;
  logic [VALUE_W-1:0]   value;
  status_t              status;

  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  acm_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (adv),
    .ch     (ch_r),
    .sample (sample_r),
    .value  (value)
  );

  acm_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (adv),
    .ch           (ch_r),
    .value        (value),
    .pins         (pins_r),
    .tick         (tick_r),
    .cfg          (cfg_r),
    .delay_wr     (cfg_wr && cfg_index == REG_DETECT_DELAY),
    .delay_wr_val (cfg_data[DELAY_W-1:0]),
    .status       (status)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
      pins_r   <= in_pin_open_bits;
      tick_r   <= in_debounce_tick;
    end
  end

  // rotation and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      ch_r      <= ch_r + 1'b1;
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch_r     <= ch_r;
      out_value_r  <= value;
      out_status_r <= status;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_limit         <= RST_OPEN_LIMIT;
      cfg_r.pin_open_limit     <= RST_PIN_OPEN_LIMIT;
      cfg_r.short_limit        <= RST_SHORT_LIMIT;
      cfg_r.leak_low           <= RST_LEAK_LOW;
      cfg_r.leak_high          <= RST_LEAK_HIGH;
      cfg_r.supply_low         <= RST_SUPPLY_LOW;
      cfg_r.supply_high        <= RST_SUPPLY_HIGH;
      cfg_r.detect_delay_scans <= RST_DETECT_DELAY;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_OPEN_LIMIT:     cfg_r.open_limit         <= cfg_data;
        REG_PIN_OPEN_LIMIT: cfg_r.pin_open_limit     <= cfg_data;
        REG_SHORT_LIMIT:    cfg_r.short_limit        <= cfg_data;
        REG_LEAK_LOW:       cfg_r.leak_low           <= cfg_data[LIMIT_W-1:0];
        REG_LEAK_HIGH:      cfg_r.leak_high          <= cfg_data[LIMIT_W-1:0];
        REG_SUPPLY_LOW:     cfg_r.supply_low         <= cfg_data[LIMIT_W-1:0];
        REG_SUPPLY_HIGH:    cfg_r.supply_high        <= cfg_data[LIMIT_W-1:0];
        REG_DETECT_DELAY:   cfg_r.detect_delay_scans <= cfg_data[DELAY_W-1:0];
      endcase
    end
  end

  assign out_valid         = out_vld_r;
  assign out_channel       = out_ch_r;
  assign out_value         = out_value_r;
  assign out_open_faults   = out_status_r.open_faults;
  assign out_short_faults  = out_status_r.short_faults;
  assign out_supply_fault  = out_status_r.supply_fault;
  assign out_leak_fault    = out_status_r.leak_fault;
  assign out_detected_mask = out_status_r.detected_mask;
  assign out_sensors_valid = out_status_r.sensors_valid;

endmodule

`default_nettype wire
